### design/wbt_pkg.sv
// ---------------------------------------------------------------------------
// wbt_pkg
// Shared types, command codes and constants of the beacon timer / irq core.
// ---------------------------------------------------------------------------
package wbt_pkg;

    // Command codes carried by an input item
    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_ACK_FLAGS  = 4'd1,
        CMD_SET_FLAGS  = 4'd2,
        CMD_WR_ENABLE  = 4'd3,
        CMD_WR_US      = 4'd4,
        CMD_WR_BEACON  = 4'd5,
        CMD_WR_CMD_CNT = 4'd6,
        CMD_WR_POST    = 4'd7,
        CMD_FORCE_BCN  = 4'd8
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_US_EN    = 3'd0,
        REG_CMP_EN   = 3'd1,
        REG_CC_EN    = 3'd2,
        REG_INTERVAL = 3'd3,
        REG_PRE      = 3'd4,
        REG_CMP      = 3'd5,
        REG_ARMED    = 3'd6
    } t_reg_idx;

    // Interrupt flag positions
    localparam int IRQ_PRE_BEACON  = 15;
    localparam int IRQ_BEACON      = 14;
    localparam int IRQ_POST_BEACON = 13;
    localparam int IRQ_CMD_COUNT   = 12;
    localparam int IRQ_TX_START    = 7;
    localparam int IRQ_TX_END      = 1;

    localparam logic [63:0] MS_STEP_US   = 64'h400;
    localparam logic [15:0] CMD_STEP     = 16'(1024 / 10);
    localparam logic [15:0] ALL_ONES     = 16'hFFFF;
    localparam logic [15:0] FLAG_MASK    = 16'hFBFF;   // bit 10 never settable
    localparam logic [63:0] CMP_MASK     = {48'hFFFF_FFFF_FFFF, 16'hFC00};

    typedef struct packed {
        logic        us_en;
        logic        cmp_en;
        logic        cc_en;
        logic [9:0]  interval;
        logic [15:0] pre;
        logic [63:0] cmp;
        logic        armed;
    } t_cfg;

    typedef struct packed {
        logic [63:0] us;
        logic [15:0] beacon;
        logic [15:0] post;
        logic [15:0] cmd_cnt;
        logic [15:0] pending;
        logic [15:0] enable;
    } t_state;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [15:0] write_value;
        logic [15:0] write_mask;
        logic [1:0]  part_index;
    } t_item;

endpackage

### design/wbt_step.sv
// ---------------------------------------------------------------------------
// wbt_step
// Next-state logic for one command item: counters, flags and cpu pulse.
// ---------------------------------------------------------------------------
module wbt_step (
    input  wbt_pkg::t_cfg   i_cfg,
    input  wbt_pkg::t_state i_cur,
    input  wbt_pkg::t_item  i_item,
    output wbt_pkg::t_state o_nxt,
    output logic            o_pulse,
    output logic            o_tx
);

    always_comb begin
        logic [15:0] raised;
        logic [15:0] bc1;
        logic [63:0] us1;
        logic [15:0] vm;
        logic [15:0] m;
        logic        idle_irq;

        o_nxt    = i_cur;
        o_pulse  = 1'b0;
        o_tx     = 1'b0;
        raised   = '0;
        vm       = i_item.write_value & i_item.write_mask;
        m        = i_item.write_mask & wbt_pkg::FLAG_MASK;
        bc1      = i_cur.beacon - 16'd1;
        us1      = i_cur.us + wbt_pkg::MS_STEP_US;
        idle_irq = ((i_cur.enable & i_cur.pending) == 16'd0);

        unique case (wbt_pkg::t_cmd'(i_item.cmd))
            wbt_pkg::CMD_TICK: begin
                if (i_cfg.us_en) begin
                    o_nxt.beacon = bc1;
                    o_nxt.us     = us1;
                    if (i_cfg.cmp_en && (bc1 == i_cfg.pre)) begin
                        raised[wbt_pkg::IRQ_PRE_BEACON] = 1'b1;
                    end
                    if ((us1 == i_cfg.cmp) || (bc1 == 16'd0)) begin
                        o_nxt.beacon = 16'(i_cfg.interval);
                        if (i_cfg.cmp_en) begin
                            raised[wbt_pkg::IRQ_BEACON] = 1'b1;
                            o_nxt.post = wbt_pkg::ALL_ONES;
                            if (i_cfg.armed) begin
                                o_tx = 1'b1;
                                raised[wbt_pkg::IRQ_TX_START] = 1'b1;
                                raised[wbt_pkg::IRQ_TX_END]   = 1'b1;
                            end
                        end
                    end
                    // post-beacon countdown sees the reload above
                    if (o_nxt.post != 16'd0) begin
                        if (o_nxt.post == 16'd1) begin
                            raised[wbt_pkg::IRQ_POST_BEACON] = 1'b1;
                        end
                        o_nxt.post = o_nxt.post - 16'd1;
                    end
                end
                if (i_cfg.cc_en) begin
                    if (i_cur.cmd_cnt <= wbt_pkg::CMD_STEP) begin
                        o_nxt.cmd_cnt = 16'd0;
                        raised[wbt_pkg::IRQ_CMD_COUNT] = 1'b1;
                    end else begin
                        o_nxt.cmd_cnt = i_cur.cmd_cnt - wbt_pkg::CMD_STEP;
                    end
                end
                // first enabled raise with nothing enabled-pending gives the pulse
                o_nxt.pending = i_cur.pending | raised;
                o_pulse = idle_irq && ((i_cur.enable & raised) != 16'd0);
            end
            wbt_pkg::CMD_ACK_FLAGS: begin
                o_nxt.pending = i_cur.pending & ~vm;
            end
            wbt_pkg::CMD_SET_FLAGS: begin
                o_pulse = idle_irq && ((i_cur.enable & vm) != 16'd0);
                o_nxt.pending = i_cur.pending | (vm & wbt_pkg::FLAG_MASK);
            end
            wbt_pkg::CMD_WR_ENABLE: begin
                o_pulse = idle_irq && ((vm & i_cur.pending) != 16'd0);
                o_nxt.enable = (i_cur.enable & ~m) | (i_item.write_value & m);
            end
            wbt_pkg::CMD_WR_US: begin
                for (int k = 0; k < 4; k++) begin
                    if (i_item.part_index == 2'(k)) begin
                        o_nxt.us[k*16 +: 16] = (i_cur.us[k*16 +: 16] & ~i_item.write_mask)
                                               | vm;
                    end
                end
            end
            wbt_pkg::CMD_WR_BEACON: begin
                o_nxt.beacon = (i_cur.beacon & ~i_item.write_mask) | vm;
            end
            wbt_pkg::CMD_WR_CMD_CNT: begin
                o_nxt.cmd_cnt = (i_cur.cmd_cnt & ~i_item.write_mask) | vm;
            end
            wbt_pkg::CMD_WR_POST: begin
                o_nxt.post = (i_cur.post & ~i_item.write_mask) | vm;
            end
            wbt_pkg::CMD_FORCE_BCN: begin
                o_pulse = idle_irq && i_cur.enable[wbt_pkg::IRQ_BEACON];
                o_nxt.pending[wbt_pkg::IRQ_BEACON] = 1'b1;
                o_nxt.post = wbt_pkg::ALL_ONES;
            end
            default: begin
                // unused codes leave everything as is
            end
        endcase
    end

endmodule

### design/wlan_beacon_timer_irq_core.sv
// ---------------------------------------------------------------------------
// wlan_beacon_timer_irq_core
// Millisecond tick timer, beacon scheduler and interrupt flag unit.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready   | cmd, write_value, mask, part
//  out     | output    | o_out_valid / i_out_ready | flags, pulses, counters
//  cfg     | input     | i_cfg_wr_en (no wait)     | i_cfg_index, i_cfg_data
//
//  From accept to result: an input register, then the next-state logic
//  (64-bit +1024 and compare) writes state and the result register.
//  One item per cycle sustained; the pipeline only holds when the result
//  register is full and not taken.
//  Reset (synchronous, active low) clears config, counters, flags and valids.
//  Config writes take effect at once; the user must issue them only while idle (not enforced here).
// ---------------------------------------------------------------------------
module wlan_beacon_timer_irq_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_cmd,
    input  logic [15:0] i_write_value,
    input  logic [15:0] i_write_mask,
    input  logic [1:0]  i_part_index,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_irq_flags,
    output logic        o_cpu_irq,
    output logic        o_beacon_tx,
    output logic [15:0] o_beacon_count_out,
    output logic [15:0] o_post_beacon_out,
    output logic [15:0] o_cmd_count_out,
    output logic [63:0] o_us_count_out
);

    wbt_pkg::t_cfg   r_cfg;
    wbt_pkg::t_state r_state;
    wbt_pkg::t_state n_state;
    wbt_pkg::t_item  r_item;
    logic            r_in_valid;
    logic            r_out_valid;
    logic            n_pulse;
    logic            n_tx;
    logic            w_advance;

    // item in the input register moves on when the result register is free or being taken
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    wbt_step u_step (
        .i_cfg   (r_cfg),
        .i_cur   (r_state),
        .i_item  (r_item),
        .o_nxt   (n_state),
        .o_pulse (n_pulse),
        .o_tx    (n_tx)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.cmd         <= i_cmd;
            r_item.write_value <= i_write_value;
            r_item.write_mask  <= i_write_mask;
            r_item.part_index  <= i_part_index;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (wbt_pkg::t_reg_idx'(i_cfg_index))
                wbt_pkg::REG_US_EN:    r_cfg.us_en    <= i_cfg_data[0];
                wbt_pkg::REG_CMP_EN:   r_cfg.cmp_en   <= i_cfg_data[0];
                wbt_pkg::REG_CC_EN:    r_cfg.cc_en    <= i_cfg_data[0];
                wbt_pkg::REG_INTERVAL: r_cfg.interval <= i_cfg_data[9:0];
                wbt_pkg::REG_PRE:      r_cfg.pre      <= i_cfg_data[15:0];
                wbt_pkg::REG_CMP:      r_cfg.cmp      <= i_cfg_data & wbt_pkg::CMP_MASK;
                wbt_pkg::REG_ARMED:    r_cfg.armed    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // timer state; an interval write also reloads the beacon counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_cfg_wr_en &&
                     (wbt_pkg::t_reg_idx'(i_cfg_index) == wbt_pkg::REG_INTERVAL)) begin
            r_state.beacon <= 16'(i_cfg_data[9:0]);
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_irq_flags        <= n_state.pending;
            o_cpu_irq          <= n_pulse;
            o_beacon_tx        <= n_tx;
            o_beacon_count_out <= n_state.beacon;
            o_post_beacon_out  <= n_state.post;
            o_cmd_count_out    <= n_state.cmd_cnt;
            o_us_count_out     <= n_state.us;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
